@@ rtl/tdd_pkg.sv @@
// Shared types, constants and register indexes for the touch delta debouncer.
`timescale 1ns / 1ps

package tdd_pkg;

    // Default width of the raw capacitive count
    localparam int COUNT_BITS_DEFAULT = 16;

    localparam int TIMER_BITS = 16;
    localparam int THR_BITS   = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX      = '1;
    localparam logic [TIMER_BITS-1:0] DEBOUNCE_RESET = 16'd200;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_TOUCH_RISE    = 2'd0,
        CFG_RELEASE_FALL  = 2'd1,
        CFG_DEBOUNCE_TIME = 2'd2,
        CFG_INVERT        = 2'd3
    } tdd_cfg_addr_t;

    // Action codes of an input transaction
    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_SAMPLE = 1'b1
    } tdd_action_t;

    typedef struct packed {
        logic [THR_BITS-1:0]   touch_min_rise;
        logic [THR_BITS-1:0]   release_min_fall;
        logic [TIMER_BITS-1:0] debounce_time;
        logic                  invert;
    } tdd_cfg_t;

    // Debounce state apart from the stored count
    typedef struct packed {
        logic                  raw_touched;
        logic                  debounced_touched;
        logic                  press_reported;
        logic                  release_reported;
        logic [TIMER_BITS-1:0] elapsed_ticks;
    } tdd_flags_t;

    typedef struct packed {
        logic pressed;
        logic press_event;
        logic release_event;
    } tdd_result_t;

endpackage

@@ rtl/tdd_step.sv @@
// Combinational update of the debounce state for one tick or sample transaction.
`timescale 1ns / 1ps

module tdd_step
    import tdd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                  action,
    input  logic [COUNT_BITS-1:0] count,
    input  tdd_cfg_t              cfg,
    input  logic [COUNT_BITS-1:0] prev_count,
    input  tdd_flags_t            flags,
    output logic [COUNT_BITS-1:0] prev_count_next,
    output tdd_flags_t            flags_next,
    output tdd_result_t           result
);

    logic [COUNT_BITS:0]   rise;
    logic [COUNT_BITS:0]   fall;
    logic [COUNT_BITS-1:0] touch_thr_ext;
    logic [COUNT_BITS-1:0] release_thr_ext;
    logic                  touch_hit;
    logic                  release_hit;
    logic                  raw_new;
    logic                  expired;
    logic                  commit;
    logic                  deb_new;
    logic                  level_new;
    logic                  press_rep_mid;
    logic                  release_rep_mid;

    // Signed differences in both directions, one bit wider than the count
    assign rise = {1'b0, count} - {1'b0, prev_count};
    assign fall = {1'b0, prev_count} - {1'b0, count};
    assign touch_thr_ext   = COUNT_BITS'(cfg.touch_min_rise);
    assign release_thr_ext = COUNT_BITS'(cfg.release_min_fall);

    assign touch_hit   = !rise[COUNT_BITS] && (rise[COUNT_BITS-1:0] > touch_thr_ext);
    assign release_hit = !fall[COUNT_BITS] && (fall[COUNT_BITS-1:0] > release_thr_ext);

    // Raw flag: touch wins over release
    always_comb
    begin
        if (touch_hit)
            raw_new = 1'b1;
        else if (release_hit)
            raw_new = 1'b0;
        else
            raw_new = flags.raw_touched;
    end

    // Commit a raw change once the timer has expired
    assign expired   = (flags.elapsed_ticks >= cfg.debounce_time);
    assign commit    = expired && (flags.debounced_touched != raw_new);
    assign deb_new   = commit ? raw_new : flags.debounced_touched;
    assign level_new = deb_new ^ cfg.invert;

    // Re-arm the opposite event on a commit
    assign press_rep_mid   = flags.press_reported && !(commit && !level_new);
    assign release_rep_mid = flags.release_reported && !(commit && level_new);

    always_comb
    begin
        prev_count_next = prev_count;
        flags_next      = flags;
        result.pressed       = flags.debounced_touched ^ cfg.invert;
        result.press_event   = 1'b0;
        result.release_event = 1'b0;
        case (tdd_action_t'(action))
            ACT_TICK:
            begin
                // Advance the timer, saturating at full scale
                if (flags.elapsed_ticks != TIMER_MAX)
                    flags_next.elapsed_ticks = flags.elapsed_ticks + 1'b1;
            end
            ACT_SAMPLE:
            begin
                prev_count_next              = count;
                flags_next.raw_touched       = raw_new;
                flags_next.debounced_touched = deb_new;
                if (commit)
                    flags_next.elapsed_ticks = '0;
                flags_next.press_reported    = press_rep_mid || level_new;
                flags_next.release_reported  = release_rep_mid || !level_new;
                result.pressed       = level_new;
                result.press_event   = level_new && !press_rep_mid;
                result.release_event = !level_new && !release_rep_mid;
            end
            default:
            begin
                prev_count_next = prev_count;
            end
        endcase
    end

endmodule

@@ rtl/touch_delta_debouncer_unit.sv @@
// Top level of the touch delta debouncer: input register, state, result register.
`timescale 1ns / 1ps

// Capacitive touch button with delta thresholds and a tick-based debounce timer.
// Input channel (in_valid/in_ready) carries action and count: action 0 is a
// one-millisecond tick, action 1 a new sensor count. Every input transaction
// yields exactly one result transaction (out_valid/out_ready) carrying the
// debounced level and one-shot press and release events.
// A transaction sits in the input register after the edge that accepts it and
// its result is loaded into the output register at the edge where the result
// slot is free. Throughput: one transaction per cycle while the receiver does
// not stall, set by the single subtract-and-compare pass between the registers.
// When the receiver stalls, the result stays in the output register and one
// more transaction is held in the input register; in_ready then drops.
// Reset clears the valid bits of both registers, the flags and the stored count,
// sets the timer to full scale (already expired) and loads the debounce time with 200 ticks.
// Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata) take effect on the
// next edge and belong only to idle periods.

module touch_delta_debouncer_unit
    import tdd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic [COUNT_BITS-1:0]    count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     pressed,
    output logic                     press_event,
    output logic                     release_event
);

    tdd_cfg_t              cfg_reg;
    logic                  in_valid_reg;
    logic                  action_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] prev_count_reg;
    logic [COUNT_BITS-1:0] prev_count_next;
    tdd_flags_t            flags_reg;
    tdd_flags_t            flags_next;
    tdd_result_t           result_next;
    tdd_result_t           result_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  in_take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_min_rise   <= '0;
            cfg_reg.release_min_fall <= '0;
            cfg_reg.debounce_time    <= DEBOUNCE_RESET;
            cfg_reg.invert           <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (tdd_cfg_addr_t'(cfg_addr))
                CFG_TOUCH_RISE:    cfg_reg.touch_min_rise   <= cfg_wdata[THR_BITS-1:0];
                CFG_RELEASE_FALL:  cfg_reg.release_min_fall <= cfg_wdata[THR_BITS-1:0];
                CFG_DEBOUNCE_TIME: cfg_reg.debounce_time    <= cfg_wdata[TIMER_BITS-1:0];
                CFG_INVERT:        cfg_reg.invert           <= cfg_wdata[0];
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Handshake: move the held transaction whenever the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg <= action;
            count_reg  <= count;
        end
    end

    tdd_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .action          (action_reg),
        .count           (count_reg),
        .cfg             (cfg_reg),
        .prev_count      (prev_count_reg),
        .flags           (flags_reg),
        .prev_count_next (prev_count_next),
        .flags_next      (flags_next),
        .result          (result_next)
    );

    // Debounce state, updated once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg               <= '0;
            flags_reg.raw_touched        <= 1'b0;
            flags_reg.debounced_touched  <= 1'b0;
            flags_reg.press_reported     <= 1'b0;
            flags_reg.release_reported   <= 1'b0;
            flags_reg.elapsed_ticks      <= TIMER_MAX;
        end
        else if (advance)
        begin
            prev_count_reg <= prev_count_next;
            flags_reg      <= flags_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign pressed       = result_reg.pressed;
    assign press_event   = result_reg.press_event;
    assign release_event = result_reg.release_event;

    // A press event always reports the pressed level
    a_press_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.press_event) |-> result_reg.pressed)
        else $error("press event without pressed level");

    // A release event always reports the released level
    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_reg.release_event) |-> !result_reg.pressed)
        else $error("release event with pressed level");

    // A committed change restarts the debounce timer
    a_commit_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg.debounced_touched != $past(flags_reg.debounced_touched))
            |-> (flags_reg.elapsed_ticks == '0))
        else $error("debounced change without timer restart");

    // Input side only backs up while a transaction is held
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a held transaction");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the touch delta debouncer unit.
`timescale 1ns / 1ps

module testbench;
    import tdd_pkg::*;

    localparam int COUNT_W      = COUNT_BITS_DEFAULT;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1300;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_PROBE   = 400;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     in_valid;
    logic                     in_ready;
    logic                     action;
    logic [COUNT_W-1:0]       count;
    logic                     out_valid;
    logic                     out_ready;
    logic                     pressed;
    logic                     press_event;
    logic                     release_event;

    // Mirror of the debouncer: configuration, stored count and flags
    tdd_cfg_t           cfg_model;
    tdd_flags_t         flags;
    logic [COUNT_W-1:0] last_count;

    tdd_result_t expected_results[$];

    bit                 calm = 1'b0;
    logic [COUNT_W-1:0] level_count = '0;
    int                 sent_items = 0;
    int                 checked_results = 0;
    int                 mismatch_count = 0;
    int                 commits = 0;
    int                 press_events = 0;
    int                 release_events = 0;
    int unsigned        cycle_count = 0;

    touch_delta_debouncer_unit #(.COUNT_BITS(COUNT_W)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .count         (count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pressed       (pressed),
        .press_event   (press_event),
        .release_event (release_event)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("touch_delta_debouncer_unit test failed");
            $finish;
        end
    end

    function automatic void reset_model();
        cfg_model.touch_min_rise    = '0;
        cfg_model.release_min_fall  = '0;
        cfg_model.debounce_time     = DEBOUNCE_RESET;
        cfg_model.invert            = 1'b0;
        flags.raw_touched           = 1'b0;
        flags.debounced_touched     = 1'b0;
        flags.press_reported        = 1'b0;
        flags.release_reported      = 1'b0;
        flags.elapsed_ticks         = TIMER_MAX;
        last_count                  = '0;
    endfunction

    // Advance the mirror by one transaction and return the result it reports
    function automatic tdd_result_t debounce_step(input tdd_action_t act,
                                                  input logic [COUNT_W-1:0] cnt);
        tdd_result_t              res;
        logic signed [COUNT_W+1:0] delta;
        logic signed [COUNT_W+1:0] rise_limit;
        logic signed [COUNT_W+1:0] fall_limit;
        logic                     lvl;
        res        = '0;
        rise_limit = $signed({{(COUNT_W+2-THR_BITS){1'b0}}, cfg_model.touch_min_rise});
        fall_limit = $signed({{(COUNT_W+2-THR_BITS){1'b0}}, cfg_model.release_min_fall});
        if (act == ACT_TICK)
        begin
            // Saturate the timer at full scale
            if (flags.elapsed_ticks != TIMER_MAX)
                flags.elapsed_ticks = flags.elapsed_ticks + 1'b1;
        end
        else
        begin
            delta      = $signed({2'b00, cnt}) - $signed({2'b00, last_count});
            last_count = cnt;
            if (delta > rise_limit)
                flags.raw_touched = 1'b1;
            else if (-delta > fall_limit)
                flags.raw_touched = 1'b0;
            // Commit once the hold time has passed, then re-arm the opposite event
            if (flags.elapsed_ticks >= cfg_model.debounce_time &&
                flags.debounced_touched != flags.raw_touched)
            begin
                flags.elapsed_ticks     = '0;
                flags.debounced_touched = flags.raw_touched;
                commits++;
                if (flags.debounced_touched ^ cfg_model.invert)
                    flags.release_reported = 1'b0;
                else
                    flags.press_reported = 1'b0;
            end
            lvl = flags.debounced_touched ^ cfg_model.invert;
            if (lvl && !flags.press_reported)
            begin
                flags.press_reported = 1'b1;
                res.press_event      = 1'b1;
                press_events++;
            end
            if (!lvl && !flags.release_reported)
            begin
                flags.release_reported = 1'b1;
                res.release_event      = 1'b1;
                release_events++;
            end
        end
        res.pressed = flags.debounced_touched ^ cfg_model.invert;
        return res;
    endfunction

    function automatic int draw_wait();
        if (calm)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 13);
        return 0;
    endfunction

    // Send one transaction; returns at the edge where it is accepted
    task automatic send_item(input tdd_action_t act, input logic [COUNT_W-1:0] cnt);
        int gap;
        bit fire;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        count    <= cnt;
        fire = 1'b0;
        while (!fire)
        begin
            @(negedge clk);
            fire = in_ready;
            @(posedge clk);
        end
        expected_results.push_back(debounce_step(act, cnt));
        sent_items++;
    endtask

    task automatic send_sample(input logic [COUNT_W-1:0] cnt);
        send_item(ACT_SAMPLE, cnt);
    endtask

    // Ticks carry random count bits, which the block must ignore
    task automatic tick_run(input int n);
        logic [COUNT_W-1:0] junk;
        int                 k;
        for (k = 0; k < n; k++)
        begin
            junk = COUNT_W'($urandom);
            send_item(ACT_TICK, junk);
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input tdd_cfg_addr_t addr, input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        case (addr)
            CFG_TOUCH_RISE:    cfg_model.touch_min_rise   = data[THR_BITS-1:0];
            CFG_RELEASE_FALL:  cfg_model.release_min_fall = data[THR_BITS-1:0];
            CFG_DEBOUNCE_TIME: cfg_model.debounce_time    = data[TIMER_BITS-1:0];
            CFG_INVERT:        cfg_model.invert           = data[0];
            default: ;
        endcase
    endtask

    // Write all registers while idle; unused upper data bits carry junk
    task automatic configure(input logic [THR_BITS-1:0] touch_thr,
                             input logic [THR_BITS-1:0] release_thr,
                             input logic [TIMER_BITS-1:0] hold_ticks,
                             input logic inv);
        logic [CFG_DATA_BITS-THR_BITS-1:0] junk_hi;
        logic [CFG_DATA_BITS-2:0]          junk_inv;
        wait_idle();
        junk_hi = (CFG_DATA_BITS-THR_BITS)'($urandom);
        write_reg(CFG_TOUCH_RISE, {junk_hi, touch_thr});
        junk_hi = (CFG_DATA_BITS-THR_BITS)'($urandom);
        write_reg(CFG_RELEASE_FALL, {junk_hi, release_thr});
        write_reg(CFG_DEBOUNCE_TIME, hold_ticks);
        junk_inv = (CFG_DATA_BITS-1)'($urandom);
        write_reg(CFG_INVERT, {junk_inv, inv});
        cfg_wr_en <= 1'b0;
    endtask

    // Reset values: zero thresholds, 200-tick hold, timer already expired
    task automatic test_reset_state();
        tick_run(1);
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h0001);
        send_sample(16'h0000);
        tick_run(1);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
    endtask

    // Deltas exactly at and one past the largest thresholds, short hold
    task automatic test_threshold_edges();
        configure(8'hFF, 8'hFF, 16'd2, 1'b0);
        send_sample(16'd100);
        send_sample(16'd355);
        send_sample(16'd611);
        tick_run(2);
        send_sample(16'd356);
        send_sample(16'd100);
        tick_run(1);
        send_sample(16'd100);
    endtask

    // Zero hold commits at once; inverted report swaps the events
    task automatic test_invert_zero_hold();
        configure(8'h00, 8'h00, 16'd0, 1'b1);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'h0000);
        tick_run(1);
        send_sample(16'h0001);
    endtask

    // Flip the raw flag with a one-count step from mid scale
    task automatic toggle_raw();
        if (flags.raw_touched)
            send_sample(last_count - 1'b1);
        else
            send_sample(last_count + 1'b1);
    endtask

    // Long hold: one tick short blocks the commit, the next one allows it;
    // then a full-scale hold keeps a fresh change pending
    task automatic test_full_scale_hold();
        calm = 1'b1;
        configure(8'h00, 8'h00, 16'd0, 1'b0);
        send_sample(16'h8000);
        toggle_raw();
        configure(8'h00, 8'h00, TIMER_BITS'(HOLD_PROBE), 1'b0);
        tick_run(HOLD_PROBE - 1);
        toggle_raw();
        tick_run(1);
        send_sample(last_count);
        tick_run(3);
        configure(8'h00, 8'h00, TIMER_MAX, 1'b0);
        toggle_raw();
        tick_run(3);
        send_sample(last_count);
        calm = 1'b0;
    endtask

    function automatic int hold_span();
        int cap;
        cap = (cfg_model.debounce_time > 40) ? 40 : int'(cfg_model.debounce_time) + 2;
        if (cfg_model.debounce_time <= 250 && $urandom_range(0, 3) == 0)
            return int'(cfg_model.debounce_time) + 1;
        return $urandom_range(0, cap);
    endfunction

    function automatic int step_size(input logic [THR_BITS-1:0] thr);
        case ($urandom_range(0, 3))
            0:       return int'(thr);
            1:       return int'(thr) + 1;
            default: return int'(thr) + $urandom_range(2, 400);
        endcase
    endfunction

    // Samples wobbling by a count or two around the current level, some ticks mixed in
    task automatic sample_near(input int n);
        int k;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                tick_run(1);
            else
                send_sample(COUNT_W'(int'(level_count) + int'($urandom_range(0, 3)) - 1));
        end
    endtask

    // One gesture: mostly clean press, hold and release; some bounce and noise
    task automatic run_gesture();
        int                 kind;
        int                 k;
        int                 n;
        logic [COUNT_W-1:0] junk;
        kind = $urandom_range(0, 9);
        if (level_count > 60000 || level_count < 1000)
            level_count = COUNT_W'($urandom_range(1000, 30000));
        if (kind <= 6)
        begin
            sample_near($urandom_range(1, 4));
            level_count = COUNT_W'(int'(level_count) + step_size(cfg_model.touch_min_rise));
            send_sample(level_count);
            sample_near($urandom_range(0, 3));
            tick_run(hold_span());
            sample_near($urandom_range(1, 3));
            level_count = COUNT_W'(int'(level_count) - step_size(cfg_model.release_min_fall));
            send_sample(level_count);
            tick_run(hold_span());
            sample_near($urandom_range(1, 3));
        end
        else if (kind == 7)
        begin
            // Bounce: repeated press and release steps, sometimes with a tick between pairs
            n = $urandom_range(2, 6);
            for (k = 0; k < n; k++)
            begin
                send_sample(COUNT_W'(int'(level_count) + step_size(cfg_model.touch_min_rise)));
                send_sample(level_count);
                if ($urandom_range(0, 1) == 1)
                    tick_run(1);
            end
        end
        else if (kind == 8)
        begin
            tick_run(hold_span());
        end
        else
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
            begin
                junk = COUNT_W'($urandom);
                send_item(tdd_action_t'($urandom_range(0, 1)), junk);
            end
        end
        // Occasionally switch between idling and back-to-back stretches
        if ($urandom_range(0, 7) == 0)
            calm = ~calm;
    endtask

    task automatic test_random_gestures();
        int phase;
        int first_item;
        int phase_end;
        first_item = sent_items;
        phase      = 0;
        while (sent_items - first_item < RANDOM_ITEMS)
        begin
            case (phase % 6)
                0: configure(8'h00, 8'hFF, 16'd0, 1'b1);
                1: configure(8'hFF, 8'h00, 16'hFFFF, 1'b0);
                2: configure(THR_BITS'($urandom_range(0, 255)),
                             THR_BITS'($urandom_range(0, 255)),
                             DEBOUNCE_RESET, 1'b0);
                default: configure(THR_BITS'($urandom_range(0, 255)),
                                   THR_BITS'($urandom_range(0, 255)),
                                   TIMER_BITS'($urandom_range(0, 24)),
                                   1'($urandom_range(0, 1)));
            endcase
            phase_end = sent_items + ((phase % 6 == 1) ? 100 : 250);
            while (sent_items < phase_end)
                run_gesture();
            phase++;
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, compare each transaction with the oldest expectation
    initial
    begin : result_checker
        tdd_result_t seen;
        tdd_result_t want;
        int          stall;
        bit          fire;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            fire = 1'b0;
            while (!fire)
            begin
                @(negedge clk);
                fire               = out_valid;
                seen.pressed       = pressed;
                seen.press_event   = press_event;
                seen.release_event = release_event;
                @(posedge clk);
            end
            checked_results++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result at cycle %0d: pressed=%b press=%b release=%b",
                             cycle_count, seen.pressed, seen.press_event,
                             seen.release_event);
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.pressed !== want.pressed || seen.press_event !== want.press_event ||
                    seen.release_event !== want.release_event)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Mismatch %0d exp/act: pressed %b/%b press_ev %b/%b rel_ev %b/%b",
                                 checked_results, want.pressed, seen.pressed,
                                 want.press_event, seen.press_event,
                                 want.release_event, seen.release_event);
                end
            end
        end
    end

    initial
    begin : main_sequence
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = CFG_TOUCH_RISE;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        count     = '0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_threshold_edges();
        test_invert_zero_hold();
        test_full_scale_hold();
        test_random_gestures();
        wait_idle();

        $display("Covered %0d transactions and %0d results: %0d debounced commits,",
                 sent_items, checked_results, commits);
        $display("%0d press and %0d release events, %0d mismatches",
                 press_events, release_events, mismatch_count);
        if (mismatch_count == 0)
            $display("touch_delta_debouncer_unit test passed");
        else
            $display("touch_delta_debouncer_unit test failed");
        $finish;
    end

endmodule
